// ===== sv/fbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbsc_pkg: shared constants and types for the frustum cull core
// Fixed-point widths, function codes and the word types that travel down the
// square-root chain and the plane-cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsc_pkg;

   // frustum planes
   localparam int PLANE_COUNT = 6;              // cells in the plane chain (1..8)
   localparam int REG_COUNT   = 6;              // writable plane registers
   localparam int CSR_IDX_W   = $clog2(REG_COUNT);
   localparam int PLANE_W     = 64;
   localparam int NORM_W      = 16;             // nx, ny, nz and d fields

   // input word fields
   localparam int COORD_W  = 16;                // Q12.4 coordinates
   localparam int RADIUS_W = 15;
   localparam int FUNC_W   = 2;
   localparam int EXT_W    = COORD_W + 1;       // sums and differences of two coordinates

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_SPHERE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FAST   = 2'd2;

   // bounding sphere of the fast box test
   localparam int SQ_W   = 2 * COORD_W;         // one squared edge
   localparam int ROOT_W = EXT_W;               // integer square root, one bit per cell
   localparam int DIAG_W = 2 * ROOT_W;          // sum of three squared edges
   localparam int REM_W  = ROOT_W + 3;          // partial remainder

   // plane distance arithmetic, everything scaled to Q.18
   localparam int NORM_SHIFT = 14;
   localparam int PROD_W     = NORM_W + EXT_W;  // n * coordinate
   localparam int DB_W       = PROD_W;          // d term plus bound term
   localparam int SUM_W      = PROD_W + 3;

   typedef struct packed {
      logic                     valid;
      logic                     visible;
      logic                     dbl_d;          // fast box: distance counted twice
      logic [ROOT_W-1:0]        bound;          // cull if distance < -bound
      logic [2:0][EXT_W-1:0]    lo;             // vertex taken for a negative normal
      logic [2:0][EXT_W-1:0]    hi;             // vertex taken for a positive normal
   } cull_item_type;

   typedef struct packed {
      logic [DIAG_W-1:0]        rad;            // radicand, consumed two bits a step
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
   } sqrt_step_type;

endpackage

`default_nettype wire

// ===== sv/fbsc_if.sv =====
// ----------------------------------------------------------------------------
// fbsc_if: channel interfaces of the frustum cull core
// Request, response and register-write channels, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbsc_req_if;
   import fbsc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic signed [COORD_W-1:0]  box_min_x;
   logic signed [COORD_W-1:0]  box_min_y;
   logic signed [COORD_W-1:0]  box_min_z;
   logic signed [COORD_W-1:0]  box_max_x;
   logic signed [COORD_W-1:0]  box_max_y;
   logic signed [COORD_W-1:0]  box_max_z;
   logic signed [COORD_W-1:0]  sphere_x;
   logic signed [COORD_W-1:0]  sphere_y;
   logic signed [COORD_W-1:0]  sphere_z;
   logic [RADIUS_W-1:0]        sphere_radius;

   modport source (
      output valid, func, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
             box_max_z, sphere_x, sphere_y, sphere_z, sphere_radius,
      input  ready
   );
   modport sink (
      input  valid, func, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
             box_max_z, sphere_x, sphere_y, sphere_z, sphere_radius,
      output ready
   );
endinterface

interface fbsc_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

interface fbsc_csr_if;
   import fbsc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [PLANE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/frustum_box_sphere_cull_core.sv =====
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull_core: bounding volume against six frustum planes
// Exact box, sphere and fast box tests, one word per clock.
// ----------------------------------------------------------------------------
// The core takes one request word per clock and returns one visible flag per
// word, in order. Throughput is one word every cycle unless the output stalls;
// a request passes three front stages (vertex select, edge squares, diagonal
// sum), the 17-cell square-root chain (one root bit per cell) and two stages
// in each plane cell before its response can be taken.
// All stages move together; the pipeline holds only while the response
// register is full and not taken, so a new request is taken in the same
// cycle that the waiting response leaves. Planes are written through the csr
// channel (index 0..5: left, right, bottom, top, near, far), which is always
// ready; writes to other indexes are dropped. Each plane is nx, ny, nz in
// bits 47:0 (Q1.14) and d in bits 63:48 (Q12.4); an all-zero plane never
// culls. Write planes only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_sphere_cull_core (
   input  logic         clock,
   input  logic         reset,
   fbsc_req_if.sink     req_bus,
   fbsc_rsp_if.source   rsp_bus,
   fbsc_csr_if.sink     csr_bus
);
   import fbsc_pkg::*;

   logic                        pipe_en;
   logic                        csr_wr;

   // front stages
   logic signed [EXT_W-1:0]     mn_e [3];
   logic signed [EXT_W-1:0]     mx_e [3];
   logic signed [EXT_W-1:0]     c_e [3];
   cull_item_type               s1_item_ff;
   cull_item_type               s1_item_in;
   logic signed [EXT_W-1:0]     s1_diff_ff [3];
   logic signed [EXT_W-1:0]     s1_diff_in [3];
   cull_item_type               s2_item_ff;
   logic [SQ_W-1:0]             s2_sq_ff [3];
   logic [SQ_W-1:0]             s2_sq_in [3];
   cull_item_type               s3_item_ff;
   logic [DIAG_W-1:0]           s3_diag_ff;
   logic [DIAG_W-1:0]           s3_diag_in;

   // square-root chain and the word delay line beside it
   sqrt_step_type               sqrt_bus [ROOT_W+1];
   cull_item_type               dl_ff [ROOT_W];
   cull_item_type               dl_in [ROOT_W];

   // plane chain
   cull_item_type               cell_bus [PLANE_COUNT+1];

   // the last plane cell's stage b is the response register
   assign pipe_en        = !cell_bus[PLANE_COUNT].valid || rsp_bus.ready;
   assign req_bus.ready  = pipe_en;
   assign rsp_bus.valid  = cell_bus[PLANE_COUNT].valid;
   assign rsp_bus.visible = cell_bus[PLANE_COUNT].visible;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid;

   // stage 1: decode the test into lo/hi vertices and a bound
   always_comb begin
      mn_e[0] = EXT_W'(req_bus.box_min_x);
      mn_e[1] = EXT_W'(req_bus.box_min_y);
      mn_e[2] = EXT_W'(req_bus.box_min_z);
      mx_e[0] = EXT_W'(req_bus.box_max_x);
      mx_e[1] = EXT_W'(req_bus.box_max_y);
      mx_e[2] = EXT_W'(req_bus.box_max_z);
      c_e[0]  = EXT_W'(req_bus.sphere_x);
      c_e[1]  = EXT_W'(req_bus.sphere_y);
      c_e[2]  = EXT_W'(req_bus.sphere_z);

      s1_item_in.valid   = req_bus.valid;
      s1_item_in.visible = 1'b1;
      s1_item_in.dbl_d   = 1'b0;
      s1_item_in.bound   = '0;
      for (int k = 0; k < 3; k++) begin
         s1_diff_in[k]    = mx_e[k] - mn_e[k];
         s1_item_in.lo[k] = mn_e[k];
         s1_item_in.hi[k] = mx_e[k];
      end

      case (req_bus.func)
         FUNC_SPHERE: begin
            s1_item_in.bound = ROOT_W'(req_bus.sphere_radius);
            for (int k = 0; k < 3; k++) begin
               s1_item_in.lo[k] = c_e[k];
               s1_item_in.hi[k] = c_e[k];
            end
         end
         FUNC_FAST: begin
            // doubled center, so the distance is taken twice
            s1_item_in.dbl_d = 1'b1;
            for (int k = 0; k < 3; k++) begin
               s1_item_in.lo[k] = mn_e[k] + mx_e[k];
               s1_item_in.hi[k] = mn_e[k] + mx_e[k];
            end
         end
         default: begin
            // exact box test, also for the unused code
            s1_item_in.bound = '0;
         end
      endcase
   end

   // stage 2: squared box edges; stage 3: squared diagonal
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_sq_in[k] = SQ_W'(s1_diff_ff[k] * s1_diff_ff[k]);
      end
      s3_diag_in = DIAG_W'(s2_sq_ff[0]) + DIAG_W'(s2_sq_ff[1]) + DIAG_W'(s2_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff.valid <= 1'b0;
         s2_item_ff.valid <= 1'b0;
         s3_item_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         s1_item_ff <= s1_item_in;
         s1_diff_ff <= s1_diff_in;
         s2_item_ff <= s1_item_ff;
         s2_sq_ff   <= s2_sq_in;
         s3_item_ff <= s2_item_ff;
         s3_diag_ff <= s3_diag_in;
      end
   end

   // square-root chain, one root bit per cell
   assign sqrt_bus[0].rad  = s3_diag_ff;
   assign sqrt_bus[0].rem  = '0;
   assign sqrt_bus[0].root = '0;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      fbsc_sqrt_cell u_sqrt_cell (
         .clock   (clock),
         .en      (pipe_en),
         .up_step (sqrt_bus[j]),
         .dn_step (sqrt_bus[j+1])
      );
   end

   // word delay line, kept in step with the root cells
   always_comb begin
      dl_in[0] = s3_item_ff;
      for (int j = 1; j < ROOT_W; j++) begin
         dl_in[j] = dl_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ROOT_W; j++) begin
            dl_ff[j].valid <= 1'b0;
         end
      end else if (pipe_en) begin
         dl_ff <= dl_in;
      end
   end

   // fast box takes the root as its bound
   always_comb begin
      cell_bus[0] = dl_ff[ROOT_W-1];
      if (dl_ff[ROOT_W-1].dbl_d) begin
         cell_bus[0].bound = sqrt_bus[ROOT_W].root;
      end
   end

   // plane chain; cells past the register list keep an all-zero plane
   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
      fbsc_plane_cell u_plane_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .wr_en    (csr_wr && (csr_bus.index == CSR_IDX_W'(i)) && (i < REG_COUNT)),
         .wr_data  (csr_bus.data),
         .item_in  (cell_bus[i]),
         .item_out (cell_bus[i+1])
      );
   end

   // sphere and fast box words carry one vertex for both normal signs
   assert property (@(posedge clock) disable iff (reset)
      s1_item_ff.valid && (s1_item_ff.dbl_d || s1_item_ff.bound != '0)
      |-> s1_item_ff.lo == s1_item_ff.hi)
      else $error("sphere word with split vertices");

   // a box word with distinct corners enters the plane chain with zero bound
   assert property (@(posedge clock) disable iff (reset)
      cell_bus[0].valid && !cell_bus[0].dbl_d && cell_bus[0].lo != cell_bus[0].hi
      |-> cell_bus[0].bound == '0)
      else $error("exact box word with nonzero bound");

   // a held pipeline keeps its front word
   assert property (@(posedge clock) disable iff (reset)
      s1_item_ff.valid && !pipe_en |=> s1_item_ff.valid && $stable(s1_item_ff.lo))
      else $error("front stage lost a word during hold");

endmodule

`default_nettype wire

// ===== sv/fbsc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fbsc_sqrt_cell: one step of the integer square root
// Brings in two radicand bits and decides one root bit, then registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_sqrt_cell (
   input  logic                    clock,
   input  logic                    en,
   input  fbsc_pkg::sqrt_step_type up_step,
   output fbsc_pkg::sqrt_step_type dn_step
);
   import fbsc_pkg::*;

   sqrt_step_type     step_ff;
   sqrt_step_type     step_in;
   logic [REM_W-1:0]  rem_pre;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_pre      = {up_step.rem[REM_W-3:0], up_step.rad[DIAG_W-1 -: 2]};
      trial        = REM_W'({up_step.root, 2'b01});
      step_in.rad  = {up_step.rad[DIAG_W-3:0], 2'b00};
      if (rem_pre >= trial) begin
         step_in.rem  = rem_pre - trial;
         step_in.root = {up_step.root[ROOT_W-2:0], 1'b1};
      end else begin
         step_in.rem  = rem_pre;
         step_in.root = {up_step.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign dn_step = step_ff;

endmodule

`default_nettype wire

// ===== sv/fbsc_plane_cell.sv =====
// ----------------------------------------------------------------------------
// fbsc_plane_cell: one frustum plane of the cull chain
// Holds one plane register, forms the plane distance of the passing word in
// two stages and clears its visible flag when the plane culls.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_plane_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        wr_en,
   input  logic [fbsc_pkg::PLANE_W-1:0] wr_data,
   input  fbsc_pkg::cull_item_type     item_in,
   output fbsc_pkg::cull_item_type     item_out
);
   import fbsc_pkg::*;

   logic [PLANE_W-1:0]        plane_ff;
   logic [PLANE_W-1:0]        plane_in;
   cull_item_type             a_ff;
   cull_item_type             a_in;
   cull_item_type             b_ff;
   cull_item_type             b_in;
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [DB_W-1:0]    db_ff;
   logic signed [DB_W-1:0]    db_in;
   logic signed [NORM_W-1:0]  nk [3];
   logic signed [EXT_W-1:0]   pk [3];
   logic signed [NORM_W-1:0]  dq;
   logic signed [DB_W-1:0]    d_term;
   logic signed [DB_W-1:0]    b_term;
   logic signed [SUM_W-1:0]   dist_sum;

   assign plane_in = wr_en ? wr_data : plane_ff;

   // stage a: positive vertex and the three products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nk[k]      = $signed(plane_ff[NORM_W*k +: NORM_W]);
         pk[k]      = nk[k][NORM_W-1] ? $signed(item_in.lo[k]) : $signed(item_in.hi[k]);
         prod_in[k] = PROD_W'(nk[k] * pk[k]);
      end
      dq     = $signed(plane_ff[PLANE_W-1 -: NORM_W]);
      d_term = item_in.dbl_d ? (DB_W'(dq) <<< (NORM_SHIFT + 1)) : (DB_W'(dq) <<< NORM_SHIFT);
      b_term = $signed(DB_W'({item_in.bound, {NORM_SHIFT{1'b0}}}));
      db_in  = d_term + b_term;
      a_in   = item_in;
   end

   // stage b: sign of distance plus bound
   always_comb begin
      dist_sum = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
               + SUM_W'(db_ff);
      b_in         = a_ff;
      b_in.visible = a_ff.visible & ~dist_sum[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff   <= '0;
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         if (en) begin
            a_ff    <= a_in;
            prod_ff <= prod_in;
            db_ff   <= db_in;
            b_ff    <= b_in;
         end
      end
   end

   assign item_out = b_ff;

   // a culled word stays culled through this plane
   assert property (@(posedge clock) disable iff (reset)
      a_ff.valid && !a_ff.visible && en |=> !b_ff.visible)
      else $error("culled word became visible in plane cell");

   // a moving word reaches stage b
   assert property (@(posedge clock) disable iff (reset)
      a_ff.valid && en |=> b_ff.valid)
      else $error("word lost between plane cell stages");

   // a held stage b keeps its word
   assert property (@(posedge clock) disable iff (reset)
      b_ff.valid && !en |=> b_ff.valid && $stable(b_ff.visible))
      else $error("held plane cell word changed");

endmodule

`default_nettype wire
